[hdl/swbm_pkg.sv]
`default_nettype none

package swbm_pkg;

  localparam int WINDOW      = 100;
  localparam int PTR_W       = $clog2(WINDOW);
  localparam int CNT_W       = $clog2(WINDOW + 1);

  localparam int TIME_W      = 32;
  localparam int BYTES_W     = 24;
  localparam int TTOT_W      = TIME_W + $clog2(WINDOW);
  localparam int BTOT_W      = BYTES_W + $clog2(WINDOW);
  localparam int ENTRY_W     = TIME_W + BYTES_W;

  localparam int SCALE_W     = 10;
  localparam logic [SCALE_W-1:0] SCALE = 10'd1000;
  localparam int NUM_W       = BTOT_W + SCALE_W;
  localparam int REM_W       = TTOT_W + 1;
  localparam int DIV_CNT_W   = $clog2(NUM_W);

  localparam int BW_W        = 31;
  localparam int HELD_W      = 7;
  localparam logic [BW_W-1:0] BW_MAX = {BW_W{1'b1}};
  localparam int MIN_ENTRIES = 2;

  localparam int IN_DATA_W   = 56;
  localparam int OUT_DATA_W  = 40;

  typedef struct packed {
    logic load_in;
    logic ram_rd;
    logic update;
    logic mul;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_stall;
  } sts_t;

endpackage

`default_nettype wire

[hdl/swbm_ram.sv]
`default_nettype none

module swbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

[hdl/swbm_ctrl.sv]
`default_nettype none

module swbm_ctrl
  import swbm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_RD;
        end
      end
      S_RD: begin
        cmd.ram_rd = 1'b1;
        state_nxt  = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!sts.out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/swbm_dp.sv]
`default_nettype none

module swbm_dp
  import swbm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cmd_t             cmd,
  output sts_t                  sts,
  input  wire logic [TIME_W-1:0]  elapsed_us,
  input  wire logic [BYTES_W-1:0] byte_count,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [BW_W-1:0]       bandwidth,
  output logic [HELD_W-1:0]     entries_held
);

  logic [TIME_W-1:0]    t_r;
  logic [BYTES_W-1:0]   b_r;
  logic [PTR_W-1:0]     ptr_r, ptr_nxt;
  logic [CNT_W-1:0]     held_r, held_nxt;
  logic [TTOT_W-1:0]    ttot_r, ttot_nxt;
  logic [BTOT_W-1:0]    btot_r, btot_nxt;
  logic [NUM_W-1:0]     num_r;
  logic [NUM_W-1:0]     quo_r;
  logic [REM_W-1:0]     rem_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 zero_r;
  logic                 out_valid_r;
  logic [BW_W-1:0]      bw_r, bw_nxt;
  logic [HELD_W-1:0]    held_out_r;

  logic [ENTRY_W-1:0]   ram_rdata;
  logic [TIME_W-1:0]    old_t;
  logic [BYTES_W-1:0]   old_b;
  logic                 full;
  logic [REM_W-1:0]     trial;
  logic [REM_W-1:0]     den;
  logic                 qbit;

  swbm_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(WINDOW)
  ) u_ring (
    .clk  (clk),
    .rd_en(cmd.ram_rd),
    .wr_en(cmd.update),
    .addr (ptr_r),
    .wdata({b_r, t_r}),
    .rdata(ram_rdata)
  );

  assign old_t = ram_rdata[TIME_W-1:0];
  assign old_b = ram_rdata[ENTRY_W-1:TIME_W];
  assign full  = (held_r == CNT_W'(WINDOW));

  // totals gain the new word and, once full, lose the one it overwrites
  always_comb begin
    ttot_nxt = ttot_r + TTOT_W'(t_r) - (full ? TTOT_W'(old_t) : '0);
    btot_nxt = btot_r + BTOT_W'(b_r) - (full ? BTOT_W'(old_b) : '0);
    ptr_nxt  = (ptr_r == PTR_W'(WINDOW - 1)) ? '0 : ptr_r + 1'b1;
    held_nxt = full ? held_r : held_r + 1'b1;
  end

  // restoring division, one quotient bit per step
  always_comb begin
    den   = {1'b0, ttot_r};
    trial = {rem_r[REM_W-2:0], num_r[NUM_W-1]};
    qbit  = (trial >= den);
  end

  always_comb begin
    if (zero_r) begin
      bw_nxt = '0;
    end else if (|quo_r[NUM_W-1:BW_W]) begin
      bw_nxt = BW_MAX;
    end else begin
      bw_nxt = quo_r[BW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      t_r <= elapsed_us;
      b_r <= byte_count;
    end
    if (cmd.mul) begin
      num_r  <= NUM_W'(btot_r) * NUM_W'(SCALE);
      zero_r <= (held_r < CNT_W'(MIN_ENTRIES)) || (ttot_r == '0);
      rem_r  <= '0;
      quo_r  <= '0;
    end else if (cmd.div_step) begin
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      rem_r <= qbit ? trial - den : trial;
      quo_r <= {quo_r[NUM_W-2:0], qbit};
    end
    if (cmd.out_load) begin
      bw_r       <= bw_nxt;
      held_out_r <= HELD_W'(held_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      held_r      <= '0;
      ttot_r      <= '0;
      btot_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.update) begin
        ptr_r  <= ptr_nxt;
        held_r <= held_nxt;
        ttot_r <= ttot_nxt;
        btot_r <= btot_nxt;
      end
      if (cmd.mul) begin
        cnt_r <= '0;
      end else if (cmd.div_step) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.div_last  = (cnt_r == DIV_CNT_W'(NUM_W - 1));
  assign sts.out_stall = out_valid_r && !out_ready;

  assign out_valid    = out_valid_r;
  assign bandwidth    = bw_r;
  assign entries_held = held_out_r;

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CNT_W'(WINDOW))
    else $error("window count beyond depth");

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r < PTR_W'(WINDOW) || WINDOW == (1 << PTR_W))
    else $error("ring pointer beyond depth");

  a_fill_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    !full |-> (CNT_W'(ptr_r) == held_r))
    else $error("write pointer out of step with fill count");

  a_load_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && !out_ready))
    else $error("result loaded over a stalled word");

endmodule

`default_nettype wire

[hdl/sliding_window_bandwidth_meter.sv]
// Sliding-window bandwidth meter.
// Input stream: one word per transfer measurement (elapsed microseconds and
// byte count). The block keeps the last WINDOW measurements in a ring RAM with
// running totals of time and bytes, dropping the oldest once the ring is full.
// Output stream: one word per input word, carrying the window bandwidth
// (bytes * 1000 / microseconds, truncated, saturated at 2^31-1; zero while
// fewer than two entries are held or the total time is zero) and the entry
// count.
// Steps after an input word is accepted: ring read, total update, scaling
// multiply, 41 steps of a restoring divider (one quotient bit per cycle),
// output load; out_tvalid is registered from the output load. The next input
// word is taken only once the previous result is loaded to the output. in_tready
// is high only while no measurement is being worked on; a finished result
// waiting in the output register does not block the next input word.
// Reset: totals, ring pointer and entry count clear; ring contents are left as
// they are and need no clearing pass: a stale slot is read but never used.
// Receiver stall: the result holds in the output register; a following result
// waits in the block until the held word is taken.
`default_nettype none

module sliding_window_bandwidth_meter
  import swbm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // elapsed_us[31:0], byte_count[55:32]
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [OUT_DATA_W-1:0] out_tdata   // bandwidth[30:0], entries_held[37:31], zero pad
);

  cmd_t             cmd;
  sts_t             sts;
  logic [BW_W-1:0]   bandwidth;
  logic [HELD_W-1:0] entries_held;

  swbm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  swbm_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .elapsed_us  (in_tdata[TIME_W-1:0]),
    .byte_count  (in_tdata[TIME_W+BYTES_W-1:TIME_W]),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .bandwidth   (bandwidth),
    .entries_held(entries_held)
  );

  assign out_tdata = OUT_DATA_W'({entries_held, bandwidth});

endmodule

`default_nettype wire
